/* rtl/bps_pkg.sv */
// Shared types and constants for the bilinear pixel sampler.
`default_nettype none
package bps_pkg;

   localparam int CoordBits = 12;   // column/row index, covers up to 4096
   localparam int FracMax   = 16;   // widest fraction carried in a command
   localparam int Channels  = 3;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  write_col;
      logic [7:0]  write_row;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [15:0] sample_x;
      logic [15:0] sample_y;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // Classified command handed from front to back.
   typedef struct packed {
      logic                 is_sample;
      logic [CoordBits-1:0] col0;
      logic [CoordBits-1:0] col1;
      logic [CoordBits-1:0] row0;
      logic [CoordBits-1:0] row1;
      logic [FracMax-1:0]   fx;
      logic [FracMax-1:0]   fy;
      logic [23:0]          pixel;
   } cmd_type;

endpackage
`default_nettype wire

/* rtl/bps_fifo.sv */
// Small synchronous FIFO used for the command and result queues.
`default_nettype none
module bps_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           din,
   output logic                            full,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                dout,
   output logic                            empty,
   output logic [$clog2(DEPTH):0]          count
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign dout    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end
endmodule
`default_nettype wire

/* rtl/bps_front.sv */
// Front end: size registers, write range check and coordinate clamping.
`default_nettype none
module bps_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   input  wire logic [1:0]         csr_index,
   input  wire logic [8:0]         csr_wdata,
   input  wire bps_pkg::req_type   req,
   output bps_pkg::cmd_type        cmd,
   output logic                    cmd_keep
);
   localparam int CB = bps_pkg::CoordBits;

   logic [8:0]    width_ff, width_in;
   logic [8:0]    height_ff, height_in;
   logic [CB-1:0] last_col, last_row;
   logic [16:0]   ipx, ipy;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            bps_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            bps_pkg::CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // last index in use: 0 acts as 1, above max acts as max
   always_comb begin
      if (width_ff == '0) last_col = '0;
      else if (32'(width_ff) > MAX_WIDTH) last_col = CB'(MAX_WIDTH - 1);
      else last_col = CB'(width_ff) - 1'b1;
      if (height_ff == '0) last_row = '0;
      else if (32'(height_ff) > MAX_HEIGHT) last_row = CB'(MAX_HEIGHT - 1);
      else last_row = CB'(height_ff) - 1'b1;
   end

   assign ipx = {1'b0, req.sample_x} >> FRAC_BITS;
   assign ipy = {1'b0, req.sample_y} >> FRAC_BITS;

   always_comb begin
      cmd           = '0;
      cmd.is_sample = (req.op == bps_pkg::OP_SAMPLE);
      cmd.pixel     = {req.red_in, req.green_in, req.blue_in};
      if (req.op == bps_pkg::OP_SAMPLE) begin
         cmd_keep = 1'b1;
         if (ipx >= 17'(last_col)) begin
            cmd.col0 = last_col;
            cmd.col1 = last_col;
         end else begin
            cmd.col0 = CB'(ipx);
            cmd.col1 = CB'(ipx) + 1'b1;
            cmd.fx   = bps_pkg::FracMax'(req.sample_x[FRAC_BITS-1:0]);
         end
         if (ipy >= 17'(last_row)) begin
            cmd.row0 = last_row;
            cmd.row1 = last_row;
         end else begin
            cmd.row0 = CB'(ipy);
            cmd.row1 = CB'(ipy) + 1'b1;
            cmd.fy   = bps_pkg::FracMax'(req.sample_y[FRAC_BITS-1:0]);
         end
      end else begin
         // writes beyond the store are dropped here
         cmd_keep  = (32'(req.write_col) < MAX_WIDTH) && (32'(req.write_row) < MAX_HEIGHT);
         cmd.col0  = CB'(req.write_col);
         cmd.row0  = CB'(req.write_row);
      end
   end
endmodule
`default_nettype wire

/* rtl/bps_back.sv */
// Back end: 2x2 parity-banked pixel store and the two-step blend pipeline.
`default_nettype none
module bps_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8,
   parameter int OUT_DEPTH  = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bps_pkg::cmd_type        cmd,
   input  wire logic                    cmd_empty,
   output logic                         cmd_pop,
   input  wire logic [$clog2(OUT_DEPTH):0] out_count,
   output logic                         out_push,
   output bps_pkg::rsp_type             out_data
);
   localparam int CW    = ($clog2(MAX_WIDTH)  < 2) ? 2 : $clog2(MAX_WIDTH);
   localparam int RW    = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
   localparam int BAW   = CW - 1 + RW - 1;
   localparam int BDEP  = 1 << BAW;
   localparam int WW    = FRAC_BITS + 1;
   localparam int TW    = 8 + WW;
   localparam int AW    = TW + WW;
   localparam int CNTW  = $clog2(OUT_DEPTH) + 1;
   localparam logic [WW-1:0] SCALE = WW'(1) << FRAC_BITS;

   logic [23:0]    mem [4][BDEP];
   logic [23:0]    rd_ff [4];
   logic [BAW-1:0] rd_addr [4];
   logic [BAW-1:0] wr_addr;
   logic [1:0]     wr_bank;
   logic           issue, wr_en;

   logic [CW-1:0]  c0, c1;
   logic [RW-1:0]  r0, r1;

   logic           s1_valid_ff;
   logic [WW-1:0]  s1_fx_ff, s1_fy_ff;
   logic           s1_c0p_ff, s1_c1p_ff, s1_r0p_ff, s1_r1p_ff;

   logic           s2_valid_ff;
   logic [WW-1:0]  s2_fy_ff;
   logic [TW-1:0]  s2_top_ff [bps_pkg::Channels];
   logic [TW-1:0]  s2_bot_ff [bps_pkg::Channels];
   logic [TW-1:0]  top_in [bps_pkg::Channels];
   logic [TW-1:0]  bot_in [bps_pkg::Channels];
   logic [23:0]    p00, p01, p10, p11;
   logic [AW-1:0]  acc [bps_pkg::Channels];
   logic [CNTW:0]  committed;

   assign c0 = cmd.col0[CW-1:0];
   assign c1 = cmd.col1[CW-1:0];
   assign r0 = cmd.row0[RW-1:0];
   assign r1 = cmd.row1[RW-1:0];

   // results already counted against the output queue
   assign committed = (CNTW+1)'(out_count) + (CNTW+1)'(s1_valid_ff)
                      + (CNTW+1)'(s2_valid_ff);
   assign issue   = !cmd_empty && (!cmd.is_sample || committed < (CNTW+1)'(OUT_DEPTH));
   assign cmd_pop = issue;
   assign wr_en   = issue && !cmd.is_sample;
   assign wr_bank = {r0[0], c0[0]};
   assign wr_addr = {r0[RW-1:1], c0[CW-1:1]};

   // bank {row parity, col parity} reads whichever neighbor has that parity
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         logic [CW-1:0] cs;
         logic [RW-1:0] rs;
         cs = (c0[0] == b[0]) ? c0 : c1;
         rs = (r0[0] == b[1]) ? r0 : r1;
         rd_addr[b] = {rs[RW-1:1], cs[CW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (wr_en && wr_bank == 2'(b)) begin
            mem[b][wr_addr] <= cmd.pixel;
         end
         rd_ff[b] <= mem[b][rd_addr[b]];
      end
   end

   always_ff @(posedge clock) begin
      s1_fx_ff  <= WW'(cmd.fx[FRAC_BITS-1:0]);
      s1_fy_ff  <= WW'(cmd.fy[FRAC_BITS-1:0]);
      s1_c0p_ff <= c0[0];
      s1_c1p_ff <= c1[0];
      s1_r0p_ff <= r0[0];
      s1_r1p_ff <= r1[0];
   end

   assign p00 = rd_ff[{s1_r0p_ff, s1_c0p_ff}];
   assign p01 = rd_ff[{s1_r0p_ff, s1_c1p_ff}];
   assign p10 = rd_ff[{s1_r1p_ff, s1_c0p_ff}];
   assign p11 = rd_ff[{s1_r1p_ff, s1_c1p_ff}];

   // horizontal blend, channel 0 red, 1 green, 2 blue
   always_comb begin
      for (int c = 0; c < bps_pkg::Channels; c++) begin
         top_in[c] = TW'(p00[16-8*c +: 8]) * TW'(SCALE - s1_fx_ff)
                   + TW'(p01[16-8*c +: 8]) * TW'(s1_fx_ff);
         bot_in[c] = TW'(p10[16-8*c +: 8]) * TW'(SCALE - s1_fx_ff)
                   + TW'(p11[16-8*c +: 8]) * TW'(s1_fx_ff);
      end
   end

   always_ff @(posedge clock) begin
      s2_fy_ff <= s1_fy_ff;
      for (int c = 0; c < bps_pkg::Channels; c++) begin
         s2_top_ff[c] <= top_in[c];
         s2_bot_ff[c] <= bot_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue && cmd.is_sample;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // vertical blend, truncated once
   always_comb begin
      for (int c = 0; c < bps_pkg::Channels; c++) begin
         acc[c] = AW'(s2_top_ff[c]) * AW'(SCALE - s2_fy_ff)
                + AW'(s2_bot_ff[c]) * AW'(s2_fy_ff);
      end
   end

   assign out_push           = s2_valid_ff;
   assign out_data.red_out   = acc[0][2*FRAC_BITS +: 8];
   assign out_data.green_out = acc[1][2*FRAC_BITS +: 8];
   assign out_data.blue_out  = acc[2][2*FRAC_BITS +: 8];
endmodule
`default_nettype wire

/* rtl/bilinear_pixel_sampler.sv */
// Top level of the bilinear RGB888 pixel sampler.
`default_nettype none
// Channel  Direction  Handshake              Payload
// req_     in         req_push / req_full    bps_pkg::req_type (write or sample)
// rsp_     out        rsp_empty / rsp_pop    bps_pkg::rsp_type (one per sample)
// csr_     in         csr_valid / csr_ready  csr_index, csr_wdata (width, height)
//
// Sustains one item per cycle unless the result side stalls; after a sample is
// accepted, its result passes bank read, horizontal blend, vertical blend into result queue.
// The four neighbors are read together from four parity banks.
// Reset clears control state only; pixels are undefined until written, so
// there is no clearing pass. Sizes reset to 256 x 256.
// A stalled result side backs up the result queue, then the command queue,
// then raises req_full; writes keep flowing until the command queue fills.
module bilinear_pixel_sampler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire bps_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output bps_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [8:0]       csr_wdata
);
   localparam int CMD_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   bps_pkg::cmd_type cmd_in, cmd_out;
   bps_pkg::rsp_type out_data;
   logic             cmd_keep, cmd_full, cmd_empty, cmd_pop, out_push, out_full;
   logic [$clog2(CMD_DEPTH):0] cmd_count;
   logic [$clog2(OUT_DEPTH):0] out_count;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;

   bps_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req(req_data), .cmd(cmd_in), .cmd_keep(cmd_keep)
   );

   // command queue between front and back
   bps_fifo #(.DEPTH(CMD_DEPTH), .WIDTH($bits(bps_pkg::cmd_type))) u_cmd_q (
      .clock(clock), .reset(reset),
      .push(req_push && cmd_keep), .din(cmd_in), .full(cmd_full),
      .pop(cmd_pop), .dout(cmd_out), .empty(cmd_empty), .count(cmd_count)
   );

   bps_back #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS),
      .OUT_DEPTH(OUT_DEPTH)
   ) u_back (
      .clock(clock), .reset(reset),
      .cmd(cmd_out), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
      .out_count(out_count), .out_push(out_push), .out_data(out_data)
   );

   // result queue; the back end never pushes without a reserved slot
   bps_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(bps_pkg::rsp_type))) u_rsp_q (
      .clock(clock), .reset(reset),
      .push(out_push), .din(out_data), .full(out_full),
      .pop(rsp_pop), .dout(rsp_data), .empty(rsp_empty), .count(out_count)
   );

   // queue status kept for visibility of occupancy
   logic unused_status;
   assign unused_status = out_full ^ (cmd_count == '0);
endmodule
`default_nettype wire

/* tb/sv/bilinear_pixel_sampler_checker.sv */
// Checker for the bilinear pixel sampler: shadow image, blend prediction, compare.
module bilinear_pixel_sampler_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      req_full,
   input  bps_pkg::req_type          req_data,
   input  logic                      rsp_empty,
   input  logic                      rsp_pop,
   input  bps_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [8:0]                csr_wdata,
   output int                        fail_count,
   output int                        pending_samples
);
   logic [23:0]       shadow_image [0:65535];
   logic [8:0]        width_reg;
   logic [8:0]        height_reg;
   bps_pkg::rsp_type  expected_pixels [$];

   assign pending_samples = expected_pixels.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      fail_count++;
   endtask

   // clamp register, split coordinate into neighbors and fraction
   function automatic void split_axis(input logic [15:0] coord, input logic [8:0] reg_val,
                                      output int lo, output int hi, output int frac);
      int dim;
      dim = (reg_val == 0) ? 1 : (reg_val > 256 ? 256 : int'(reg_val));
      if (int'(coord >> 8) >= dim - 1) begin
         lo = dim - 1; hi = dim - 1; frac = 0;
      end else begin
         lo = int'(coord >> 8); hi = lo + 1; frac = int'(coord[7:0]);
      end
   endfunction

   function automatic bps_pkg::rsp_type blend_sample(input bps_pkg::req_type r);
      int x0, x1, fx, y0, y1, fy, c;
      logic [23:0] p00, p01, p10, p11;
      longint top, bot, acc;
      logic [7:0] ch [3];
      bps_pkg::rsp_type res;
      split_axis(r.sample_x, width_reg, x0, x1, fx);
      split_axis(r.sample_y, height_reg, y0, y1, fy);
      p00 = shadow_image[y0*256 + x0];
      p01 = shadow_image[y0*256 + x1];
      p10 = shadow_image[y1*256 + x0];
      p11 = shadow_image[y1*256 + x1];
      for (c = 0; c < 3; c++) begin
         top = p00[16-8*c +: 8] * (256 - fx) + p01[16-8*c +: 8] * fx;
         bot = p10[16-8*c +: 8] * (256 - fx) + p11[16-8*c +: 8] * fx;
         acc = top * (256 - fy) + bot * fy;
         ch[c] = 8'(acc >> 16);
      end
      res.red_out = ch[0]; res.green_out = ch[1]; res.blue_out = ch[2];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg <= 9'd256;
         height_reg <= 9'd256;
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == bps_pkg::CSR_WIDTH) width_reg <= csr_wdata;
            else if (csr_index == bps_pkg::CSR_HEIGHT) height_reg <= csr_wdata;
         end
         if (req_push && !req_full) begin
            if (req_data.op == bps_pkg::OP_WRITE)
               shadow_image[{req_data.write_row, req_data.write_col}] =
                  {req_data.red_in, req_data.green_in, req_data.blue_in};
            else
               expected_pixels.push_back(blend_sample(req_data));
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result, red", rsp_data.red_out, 0);
            end else begin
               bps_pkg::rsp_type want;
               want = expected_pixels.pop_front();
               if (rsp_data.red_out !== want.red_out)
                  report_mismatch("red", rsp_data.red_out, want.red_out);
               if (rsp_data.green_out !== want.green_out)
                  report_mismatch("green", rsp_data.green_out, want.green_out);
               if (rsp_data.blue_out !== want.blue_out)
                  report_mismatch("blue", rsp_data.blue_out, want.blue_out);
            end
         end
      end
   end
endmodule

/* tb/sv/bilinear_pixel_sampler_tb.sv */
// Testbench top: stimulus and verdict for the bilinear pixel sampler.
module bilinear_pixel_sampler_tb;
   logic              clock = 0;
   logic              reset = 1;
   logic              req_push = 0;
   logic              req_full;
   bps_pkg::req_type  req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 0;
   bps_pkg::rsp_type  rsp_data;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [8:0]        csr_wdata = '0;
   int                fail_count;
   int                pending_samples;
   int                cycle_count = 0;
   bit                stim_done = 0;

   // Worst case: ~2000 items each with random idle gaps on both sides, plus the
   // pipe drain; CycleLimit is set several times above that.
   localparam int CycleLimit = 200000;

   always #2 clock = ~clock;

   bilinear_pixel_sampler dut (.*);

   bilinear_pixel_sampler_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stall drawn per item, often none at all.
   initial begin : drain
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_pop <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1;
         @(posedge clock iff !rsp_empty);
      end
   end

   // Each phase writes its whole active area before sampling; this tracks
   // which entries are written so no unwritten pixel is read.
   bit written [0:65535];
   int active_w = 256, active_h = 256;
   bit calm = 0;

   task automatic send_item(input bps_pkg::req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_data <= r;
      @(posedge clock iff !req_full);
      if (r.op == bps_pkg::OP_WRITE) written[{r.write_row, r.write_col}] = 1;
   endtask

   task automatic write_pixel(input int col, input int row);
      bps_pkg::req_type r;
      r = '0;
      r.op = bps_pkg::OP_WRITE; r.write_col = 8'(col); r.write_row = 8'(row);
      r.red_in = 8'($urandom); r.green_in = 8'($urandom); r.blue_in = 8'($urandom);
      r.sample_x = 16'($urandom); r.sample_y = 16'($urandom);
      send_item(r);
   endtask

   task automatic sample_at(input logic [15:0] sx, input logic [15:0] sy);
      bps_pkg::req_type r;
      r = '0;
      r.op = bps_pkg::OP_SAMPLE;
      r.write_col = 8'($urandom); r.write_row = 8'($urandom);
      r.red_in = 8'($urandom); r.green_in = 8'($urandom); r.blue_in = 8'($urandom);
      r.sample_x = sx; r.sample_y = sy;
      send_item(r);
   endtask

   // Coordinate whose neighbors stay within the written area.
   function automatic logic [15:0] rand_coord(input int dim);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'hFFFF;
      if (pick == 1) return 16'($urandom);
      if (pick == 2) return 16'((dim - 1) << 8);
      return 16'($urandom_range(0, dim * 256 - 1));
   endfunction

   task automatic write_csr(input bps_pkg::csr_index_type idx, input int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= 9'(value);
      @(posedge clock iff csr_ready);
      csr_valid <= 0;
   endtask

   // Idle point: all results back, then let the pipe empty out.
   task automatic settle();
      req_push <= 0;
      wait (pending_samples == 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase, n, c, r;
      int widths [6] = '{1, 256, 2, 17, 0, 300};
      int heights [6] = '{256, 1, 2, 9, 511, 0};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: fill a 4x4 corner, then fraction, integer and edge samples.
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++) write_pixel(c, r);
      write_pixel(255, 255);
      write_pixel(255, 0);
      write_pixel(0, 255);
      settle();
      write_csr(bps_pkg::CSR_WIDTH, 4);
      write_csr(bps_pkg::CSR_HEIGHT, 4);
      sample_at(16'h0000, 16'h0000);   // integer coordinate, floor pixel
      sample_at(16'h0180, 16'h0240);   // fraction in both axes
      sample_at(16'h00FF, 16'h00FF);   // largest fraction
      sample_at(16'hFFFF, 16'h0101);   // past last column
      sample_at(16'h0300, 16'hFFFF);   // exactly last column, past last row
      settle();

      // Random phases across register settings, extremes included.
      for (phase = 0; phase < 6; phase++) begin
         write_csr(bps_pkg::CSR_WIDTH, widths[phase]);
         write_csr(bps_pkg::CSR_HEIGHT, heights[phase]);
         active_w = (widths[phase] == 0) ? 1 : (widths[phase] > 256 ? 256 : widths[phase]);
         active_h = (heights[phase] == 0) ? 1 : (heights[phase] > 256 ? 256 : heights[phase]);
         // fill the active area so every sample reads written pixels
         calm = 1;
         for (r = 0; r < active_h; r++)
            for (c = 0; c < active_w; c++)
               if (!written[r*256+c]) write_pixel(c, r);
         calm = 0;
         for (n = 0; n < 200; n++) begin
            calm = (n % 100) > 80;
            if ($urandom_range(0, 2) == 0) write_pixel($urandom, $urandom);
            else sample_at(rand_coord(active_w), rand_coord(active_h));
         end
         settle();
      end
      stim_done = 1;
   end

   initial begin : verdict
      wait (stim_done);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_samples == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

/* filelist.f */
rtl/bps_pkg.sv
rtl/bps_fifo.sv
rtl/bps_front.sv
rtl/bps_back.sv
rtl/bilinear_pixel_sampler.sv
tb/sv/bilinear_pixel_sampler_checker.sv
tb/sv/bilinear_pixel_sampler_tb.sv
